FILE: sv/cfrs_pkg.sv
package cfrs_pkg;

	localparam int VEC_FRAC_BITS = 14;
	localparam int TEX_FRAC      = 16;

	localparam int COORD_W = 32;
	localparam int VEC_W   = 16;
	localparam int WV_W    = 49;   // working vector: cross product of a unit and a 32 bit ray
	localparam int MAG_W   = 48;
	localparam int SQ_W    = 64;
	localparam int ROOT_W  = 32;
	localparam int SEG_W   = 34;
	localparam int DIV_RW  = 32;
	localparam int DIV_QW  = SEG_W + TEX_FRAC;
	localparam int DIV_CW  = 6;

	localparam int CFG_IW = 3;
	localparam int CFG_DW = 32;
	localparam int IN_DW  = 96;
	localparam int OUT_DW = 272;

	localparam logic [CFG_IW-1:0] REG_EYE_X   = 3'd0;
	localparam logic [CFG_IW-1:0] REG_EYE_Y   = 3'd1;
	localparam logic [CFG_IW-1:0] REG_EYE_Z   = 3'd2;
	localparam logic [CFG_IW-1:0] REG_CHAIN_W = 3'd3;
	localparam logic [CFG_IW-1:0] REG_TEX_LEN = 3'd4;

	localparam logic [30:0] CW_RESET = 31'd6554;
	localparam logic [30:0] TL_RESET = 31'd13107;
	localparam logic [VEC_W-1:0] VEC_MAX = 16'd32767;

	typedef enum logic [4:0] {
		ST_IDLE, ST_LOAD, ST_SHRINK, ST_SQ, ST_SQ_ACC, ST_SQRT, ST_SQRT_WAIT,
		ST_DIV, ST_DIV_WAIT, ST_CROSS, ST_CROSS_ACC, ST_AVG, ST_OFF, ST_OFF_ACC,
		ST_OUT_TOP, ST_OUT_BOT, ST_TEX, ST_TEX_WAIT, ST_POST, ST_CLEAR
	} state_t;

	typedef enum logic [1:0] {VK_RAY, VK_SEG, VK_BIN, VK_NRM} vkind_t;

	typedef struct packed {
		logic busy;
		logic done;
	} ustat_t;

	function automatic logic [1:0] inc3(input logic [1:0] x);
		return (x == 2'd2) ? 2'd0 : x + 2'd1;
	endfunction

endpackage

FILE: sv/cfrs_mul.sv
module cfrs_mul (
	input  logic               clk,
	input  logic signed [31:0] a,
	input  logic signed [31:0] b,
	output logic signed [63:0] p
);
	// registered product
	always_ff @(posedge clk) begin
		p <= a * b;
	end
endmodule

FILE: sv/cfrs_sqrt.sv
module cfrs_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [cfrs_pkg::SQ_W-1:0]     x,
	output logic [cfrs_pkg::ROOT_W-1:0]   root,
	output cfrs_pkg::ustat_t              stat
);
	import cfrs_pkg::*;

	logic [SQ_W-1:0] x_q, r_q, bit_q, trial;
	logic            busy_q, done_q, ge;

	assign trial = r_q + bit_q;
	assign ge    = x_q >= trial;
	assign root  = r_q[ROOT_W-1:0];
	assign stat  = '{busy: busy_q, done: done_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// one result bit per cycle, two radicand bits per step
	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= x;
			r_q   <= '0;
			bit_q <= SQ_W'(1) << (SQ_W - 2);
		end else if (busy_q) begin
			if (ge) begin
				x_q <= x_q - trial;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end
endmodule

FILE: sv/cfrs_div.sv
module cfrs_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [cfrs_pkg::DIV_RW-1:0]   r_init,
	input  logic [cfrs_pkg::DIV_QW-1:0]   q_init,
	input  logic [cfrs_pkg::DIV_RW-1:0]   den,
	input  logic [cfrs_pkg::DIV_CW-1:0]   steps,
	output logic [cfrs_pkg::DIV_QW-1:0]   quo,
	output cfrs_pkg::ustat_t              stat
);
	import cfrs_pkg::*;

	logic [DIV_RW-1:0] r_q, d_q;
	logic [DIV_QW-1:0] q_q;
	logic [DIV_CW-1:0] cnt_q;
	logic              busy_q, done_q, ge;
	logic [DIV_RW:0]   r2, diff;

	// restoring divide: shift in one numerator bit, trial subtract
	assign r2   = {r_q, q_q[DIV_QW-1]};
	assign diff = r2 - {1'b0, d_q};
	assign ge   = r2 >= {1'b0, d_q};
	assign quo  = q_q;
	assign stat = '{busy: busy_q, done: done_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= r_init;
			q_q <= q_init;
			d_q <= den;
		end else if (busy_q) begin
			r_q <= ge ? diff[DIV_RW-1:0] : r2[DIV_RW-1:0];
			q_q <= {q_q[DIV_QW-2:0], ge};
		end
	end
endmodule

FILE: sv/camera_facing_ribbon_strip_unit.sv
// Camera-facing ribbon strip builder.
// Input channel s_axis_*: one polyline point per transfer, tlast marks the
// final point. Output channel m_axis_*: vertices, top (tuser 0) then bottom
// (tuser 1) of each pair; tlast is set on the bottom vertex of the last pair.
// Config port: cfg_we/cfg_idx/cfg_wdata, one register per cycle, write only
// while the block is idle (0..2 eye xyz, 3 ribbon width, 4 texture length).
// Throughput: one point at a time. A first point that is not final only
// passes through the post state. A point that closes a segment runs
// three normalisations, each a shrink shift (one bit a cycle), three squares
// on the shared 32x32 multiplier, a 32-step square root and three 15-step
// divides, plus two cross products, the offset products and a 50-step
// divide for the texture step. A final point then adds its closing pair.
// All of this runs through one multiplier, one root unit and one divider
// under the sequencer below.
// Results sit in an output register: a stalled receiver holds the sequencer
// only at the two vertex hand-off states; a point may be taken while the
// last vertex still waits.
// Reset: async, active low; state cleared, width 6554, texture length 13107.
module camera_facing_ribbon_strip_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [cfrs_pkg::IN_DW-1:0]     s_axis_tdata,  // point_x, point_y, point_z
	input  logic                           s_axis_tlast,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// pos_x, pos_y, pos_z, normal_packed, binormal_packed, tangent_packed, tex_v
	output logic [cfrs_pkg::OUT_DW-1:0]    m_axis_tdata,
	output logic [0:0]                     m_axis_tuser,  // bottom_side
	output logic                           m_axis_tlast,
	input  logic                           cfg_we,
	input  logic [cfrs_pkg::CFG_IW-1:0]    cfg_idx,
	input  logic [cfrs_pkg::CFG_DW-1:0]    cfg_wdata
);
	import cfrs_pkg::*;

	localparam int OFF_SH = VEC_FRAC_BITS + 1;

	state_t state_q, state_d;
	vkind_t kind_q;

	// configuration
	logic signed [COORD_W-1:0] eye_q [3];
	logic [30:0]               cw_q, tl_q;

	// strip state
	logic signed [COORD_W-1:0] prev_pt_q [3];
	logic signed [VEC_W-1:0]   prev_n_q [3], prev_b_q [3], prev_t_q [3];
	logic [31:0]               tex_q;
	logic                      have_pt_q, have_bs_q;

	// working registers
	logic signed [COORD_W-1:0] p_q [3], rs_q [3], ep_q [3], off_q [3];
	logic                      last_q, elast_q;
	logic signed [WV_W-1:0]    w_q [3];
	logic [MAG_W-1:0]          mag_q [3];
	logic                      neg_q [3];
	logic [4:0]                sh_q;
	logic [1:0]                idx_q;
	logic [2:0]                cnt_q;
	logic [SQ_W-1:0]           sum_q;
	logic [ROOT_W-1:0]         len_q;
	logic [SEG_W-1:0]          seg_q;
	logic signed [VEC_W-1:0]   t_q [3], b_q [3], n_q [3];
	logic signed [VEC_W-1:0]   en_q [3], eb_q [3], et_q [3];

	// output register
	logic                      ov_q, ou_q, ol_q;
	logic [OUT_DW-1:0]         od_q;

	// shared units
	logic signed [31:0]        mul_a, mul_b;
	logic signed [63:0]        mul_p;
	logic                      sq_start, dv_start;
	logic [ROOT_W-1:0]         sq_root;
	ustat_t                    sq_stat, dv_stat;
	logic [DIV_RW-1:0]         dv_rinit, dv_den;
	logic [DIV_QW-1:0]         dv_qinit, dv_quo;
	logic [DIV_CW-1:0]         dv_steps;

	logic                      s_fire, big, out_free, out_top, out_bot;
	logic signed [COORD_W-1:0] pin [3];
	logic signed [WV_W-1:0]    ray [3], dseg [3];
	logic [1:0]                ck, ck1, ck2;
	logic [VEC_W-1:0]          qc;
	logic signed [VEC_W-1:0]   cval;
	logic signed [63:0]        off_adj;
	logic signed [COORD_W-1:0] off_v;
	logic [50:0]               tex_sum;
	logic signed [VEC_W-1:0]   avg_n [3], avg_b [3], avg_t [3];
	logic [OUT_DW-1:0]         top_data, bot_data;
	state_t                    post_norm;

	function automatic logic signed [VEC_W-1:0] avg2(input logic signed [VEC_W-1:0] a,
	                                                 input logic signed [VEC_W-1:0] b);
		logic signed [VEC_W:0] s;
		logic signed [VEC_W:0] s2;
		s  = (VEC_W+1)'(a) + (VEC_W+1)'(b);
		s2 = s + {{VEC_W{1'b0}}, s[VEC_W]};   // round toward zero
		return s2[VEC_W:1];
	endfunction

	function automatic logic [COORD_W-1:0] sat32(input logic signed [COORD_W+1:0] v);
		if (v > (COORD_W+2)'(34'sh0_7FFF_FFFF)) return 32'h7FFF_FFFF;
		if (v < -(COORD_W+2)'(34'sh0_8000_0000)) return 32'h8000_0000;
		return v[COORD_W-1:0];
	endfunction

	function automatic logic [3*VEC_W-1:0] pack3(input logic signed [VEC_W-1:0] v [3]);
		return {v[0], v[1], v[2]};
	endfunction

	function automatic logic [OUT_DW-1:0] vertex(input logic bottom,
	                                             input logic signed [COORD_W-1:0] ep [3],
	                                             input logic signed [COORD_W-1:0] off [3],
	                                             input logic [3*VEC_W-1:0] pn,
	                                             input logic [3*VEC_W-1:0] pb,
	                                             input logic [3*VEC_W-1:0] pt,
	                                             input logic [31:0] tv);
		logic [COORD_W-1:0] pos [3];
		for (int i = 0; i < 3; i++) begin
			pos[i] = bottom ? sat32((COORD_W+2)'(ep[i]) - (COORD_W+2)'(off[i]))
			                : sat32((COORD_W+2)'(ep[i]) + (COORD_W+2)'(off[i]));
		end
		return {tv, pt, pb, pn, pos[2], pos[1], pos[0]};
	endfunction

	cfrs_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

	cfrs_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .x(sum_q),
		.root(sq_root), .stat(sq_stat)
	);

	cfrs_div u_div (
		.clk(clk), .arst_n(arst_n), .start(dv_start), .r_init(dv_rinit),
		.q_init(dv_qinit), .den(dv_den), .steps(dv_steps), .quo(dv_quo), .stat(dv_stat)
	);

	// datapath helpers
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pin[i]  = s_axis_tdata[i*COORD_W +: COORD_W];
			// eye ray: twice the midpoint minus twice the eye
			ray[i]  = WV_W'(prev_pt_q[i]) + WV_W'(pin[i]) - (WV_W'(eye_q[i]) <<< 1);
			dseg[i] = WV_W'(p_q[i]) - WV_W'(prev_pt_q[i]);
			avg_n[i] = have_bs_q ? avg2(n_q[i], prev_n_q[i]) : n_q[i];
			avg_b[i] = have_bs_q ? avg2(b_q[i], prev_b_q[i]) : b_q[i];
			avg_t[i] = have_bs_q ? avg2(t_q[i], prev_t_q[i]) : t_q[i];
		end
		s_fire   = s_axis_tvalid & s_axis_tready;
		big      = (|mag_q[0][MAG_W-1:31]) | (|mag_q[1][MAG_W-1:31]) |
		           (|mag_q[2][MAG_W-1:31]);
		out_free = !ov_q || m_axis_tready;
		ck       = cnt_q[2:1];
		ck1      = inc3(ck);
		ck2      = inc3(ck1);
		qc       = (dv_quo > DIV_QW'(VEC_MAX)) ? VEC_MAX : dv_quo[VEC_W-1:0];
		cval     = neg_q[idx_q] ? -$signed(qc) : $signed(qc);
		// offset: product over 2^(frac+1), toward zero
		off_adj  = mul_p + (mul_p[63] ? 64'((64'd1 << OFF_SH) - 64'd1) : 64'd0);
		off_v    = off_adj[OFF_SH +: COORD_W];
		tex_sum  = {19'd0, tex_q} + {1'b0, dv_quo};
		post_norm = (kind_q == VK_NRM) ? ST_AVG : ST_CROSS;
		top_data = vertex(1'b0, ep_q, off_q, pack3(en_q), pack3(eb_q), pack3(et_q), tex_q);
		bot_data = vertex(1'b1, ep_q, off_q, pack3(en_q), pack3(eb_q), pack3(et_q), tex_q);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:      if (s_fire) state_d = have_pt_q ? ST_LOAD : ST_POST;
			ST_LOAD:      state_d = ST_SHRINK;
			ST_SHRINK:    if (!big) state_d = (kind_q == VK_RAY) ? ST_LOAD : ST_SQ;
			ST_SQ:        state_d = ST_SQ_ACC;
			ST_SQ_ACC:    state_d = (idx_q == 2'd2) ? ST_SQRT : ST_SQ;
			ST_SQRT:      state_d = ST_SQRT_WAIT;
			ST_SQRT_WAIT: if (sq_stat.done) state_d = (sq_root == '0) ? post_norm : ST_DIV;
			ST_DIV:       state_d = ST_DIV_WAIT;
			ST_DIV_WAIT:  if (dv_stat.done) state_d = (idx_q == 2'd2) ? post_norm : ST_DIV;
			ST_CROSS:     state_d = ST_CROSS_ACC;
			ST_CROSS_ACC: state_d = (cnt_q == 3'd5) ? ST_LOAD : ST_CROSS;
			ST_AVG:       state_d = ST_OFF;
			ST_OFF:       state_d = ST_OFF_ACC;
			ST_OFF_ACC:   state_d = (idx_q == 2'd2) ? ST_OUT_TOP : ST_OFF;
			ST_OUT_TOP:   if (out_free) state_d = ST_OUT_BOT;
			ST_OUT_BOT:   if (out_free) state_d = elast_q ? ST_CLEAR : ST_TEX;
			ST_TEX:       state_d = ST_TEX_WAIT;
			ST_TEX_WAIT:  if (dv_stat.done) state_d = ST_POST;
			ST_POST:      state_d = last_q ? ST_OFF : ST_IDLE;
			ST_CLEAR:     state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs: unit operands and strobes
	always_comb begin
		s_axis_tready = 1'b0;
		mul_a    = '0;
		mul_b    = '0;
		sq_start = 1'b0;
		dv_start = 1'b0;
		dv_rinit = '0;
		dv_qinit = '0;
		dv_den   = '0;
		dv_steps = '0;
		out_top  = 1'b0;
		out_bot  = 1'b0;
		case (state_q)
			ST_IDLE: s_axis_tready = 1'b1;
			ST_SQ: begin
				mul_a = {1'b0, mag_q[idx_q][30:0]};
				mul_b = {1'b0, mag_q[idx_q][30:0]};
			end
			ST_SQRT: sq_start = 1'b1;
			ST_DIV: begin
				// (m << frac) / len; m <= len, so quotient fits frac+1 bits
				dv_start = 1'b1;
				dv_rinit = {2'b00, mag_q[idx_q][30:1]};
				dv_qinit = {mag_q[idx_q][0], {(DIV_QW-1){1'b0}}};
				dv_den   = len_q;
				dv_steps = DIV_CW'(VEC_FRAC_BITS + 1);
			end
			ST_CROSS: begin
				mul_a = cnt_q[0] ? 32'(t_q[ck2]) : 32'(t_q[ck1]);
				if (kind_q == VK_SEG)
					mul_b = cnt_q[0] ? rs_q[ck1] : rs_q[ck2];
				else
					mul_b = cnt_q[0] ? 32'(b_q[ck1]) : 32'(b_q[ck2]);
			end
			ST_OFF: begin
				mul_a = 32'(eb_q[idx_q]);
				mul_b = {1'b0, cw_q};
			end
			ST_TEX: begin
				dv_start = 1'b1;
				dv_qinit = {seg_q, {TEX_FRAC{1'b0}}};
				dv_den   = (tl_q == '0) ? DIV_RW'(1) : {1'b0, tl_q};
				dv_steps = DIV_CW'(DIV_QW);
			end
			ST_OUT_TOP: out_top = out_free;
			ST_OUT_BOT: out_bot = out_free;
			default: ;
		endcase
	end

	// control and strip state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			kind_q    <= VK_RAY;
			idx_q     <= '0;
			cnt_q     <= '0;
			last_q    <= 1'b0;
			elast_q   <= 1'b0;
			ov_q      <= 1'b0;
			cw_q      <= CW_RESET;
			tl_q      <= TL_RESET;
			tex_q     <= '0;
			have_pt_q <= 1'b0;
			have_bs_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				eye_q[i]     <= '0;
				prev_pt_q[i] <= '0;
				prev_n_q[i]  <= '0;
				prev_b_q[i]  <= '0;
				prev_t_q[i]  <= '0;
			end
		end else begin
			state_q <= state_d;

			if (cfg_we) begin
				case (cfg_idx)
					REG_EYE_X:   eye_q[0] <= cfg_wdata;
					REG_EYE_Y:   eye_q[1] <= cfg_wdata;
					REG_EYE_Z:   eye_q[2] <= cfg_wdata;
					REG_CHAIN_W: cw_q     <= cfg_wdata[30:0];
					REG_TEX_LEN: tl_q     <= cfg_wdata[30:0];
					default: ;
				endcase
			end

			if (out_top || out_bot)
				ov_q <= 1'b1;
			else if (m_axis_tready)
				ov_q <= 1'b0;

			case (state_q)
				ST_IDLE: if (s_fire) begin
					last_q <= s_axis_tlast;
					kind_q <= VK_RAY;
					if (!have_pt_q) begin
						have_pt_q <= 1'b1;
						for (int i = 0; i < 3; i++) prev_pt_q[i] <= pin[i];
					end
				end
				ST_SHRINK: if (!big) begin
					idx_q <= '0;
					if (kind_q == VK_RAY) kind_q <= VK_SEG;
				end
				ST_SQ_ACC: idx_q <= inc3(idx_q);
				ST_SQRT_WAIT: if (sq_stat.done) begin
					idx_q <= '0;
					cnt_q <= '0;
				end
				ST_DIV_WAIT: if (dv_stat.done) begin
					idx_q <= inc3(idx_q);
					cnt_q <= '0;
				end
				ST_CROSS_ACC: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd5) kind_q <= (kind_q == VK_SEG) ? VK_BIN : VK_NRM;
				end
				ST_AVG: begin
					idx_q   <= '0;
					elast_q <= 1'b0;
				end
				ST_OFF_ACC: idx_q <= inc3(idx_q);
				ST_TEX_WAIT: if (dv_stat.done) begin
					tex_q     <= (|tex_sum[50:32]) ? 32'hFFFF_FFFF : tex_sum[31:0];
					have_bs_q <= 1'b1;
					for (int i = 0; i < 3; i++) begin
						prev_n_q[i]  <= n_q[i];
						prev_b_q[i]  <= b_q[i];
						prev_t_q[i]  <= t_q[i];
						prev_pt_q[i] <= p_q[i];
					end
				end
				ST_POST: if (last_q) begin
					elast_q <= 1'b1;
					idx_q   <= '0;
				end
				ST_CLEAR: begin
					tex_q     <= '0;
					have_pt_q <= 1'b0;
					have_bs_q <= 1'b0;
					for (int i = 0; i < 3; i++) begin
						prev_pt_q[i] <= '0;
						prev_n_q[i]  <= '0;
						prev_b_q[i]  <= '0;
						prev_t_q[i]  <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// working data
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (s_fire) begin
				for (int i = 0; i < 3; i++) begin
					p_q[i] <= pin[i];
					w_q[i] <= ray[i];
				end
			end
			ST_LOAD: begin
				sh_q <= '0;
				for (int i = 0; i < 3; i++) begin
					mag_q[i] <= w_q[i][WV_W-1] ? MAG_W'(-w_q[i]) : MAG_W'(w_q[i]);
					neg_q[i] <= w_q[i][WV_W-1];
				end
			end
			ST_SHRINK: begin
				if (big) begin
					sh_q <= sh_q + 5'd1;
					for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
				end else if (kind_q == VK_RAY) begin
					for (int i = 0; i < 3; i++) begin
						rs_q[i] <= neg_q[i] ? -$signed({1'b0, mag_q[i][30:0]})
						                    : $signed({1'b0, mag_q[i][30:0]});
						w_q[i]  <= dseg[i];
					end
				end else begin
					sum_q <= '0;
				end
			end
			ST_SQ_ACC: sum_q <= sum_q + SQ_W'(mul_p);
			ST_SQRT_WAIT: if (sq_stat.done) begin
				len_q <= sq_root;
				if (kind_q == VK_SEG) seg_q <= SEG_W'(sq_root) << sh_q;
				if (sq_root == '0) begin
					// zero length: vector normalises to zero
					for (int i = 0; i < 3; i++) begin
						case (kind_q)
							VK_SEG:  t_q[i] <= '0;
							VK_BIN:  b_q[i] <= '0;
							default: n_q[i] <= '0;
						endcase
					end
				end
			end
			ST_DIV_WAIT: if (dv_stat.done) begin
				case (kind_q)
					VK_SEG:  t_q[idx_q] <= cval;
					VK_BIN:  b_q[idx_q] <= cval;
					default: n_q[idx_q] <= cval;
				endcase
			end
			ST_CROSS_ACC: begin
				if (cnt_q[0])
					w_q[ck] <= w_q[ck] - WV_W'(mul_p);
				else
					w_q[ck] <= WV_W'(mul_p);
			end
			ST_AVG: begin
				for (int i = 0; i < 3; i++) begin
					en_q[i] <= avg_n[i];
					eb_q[i] <= avg_b[i];
					et_q[i] <= avg_t[i];
					ep_q[i] <= prev_pt_q[i];
				end
			end
			ST_OFF_ACC: off_q[idx_q] <= off_v;
			ST_OUT_TOP: if (out_free) begin
				od_q <= top_data;
				ou_q <= 1'b0;
				ol_q <= 1'b0;
			end
			ST_OUT_BOT: if (out_free) begin
				od_q <= bot_data;
				ou_q <= 1'b1;
				ol_q <= elast_q;
			end
			ST_POST: if (last_q) begin
				// closing pair at this point, last basis, no averaging
				for (int i = 0; i < 3; i++) begin
					en_q[i] <= prev_n_q[i];
					eb_q[i] <= prev_b_q[i];
					et_q[i] <= prev_t_q[i];
					ep_q[i] <= p_q[i];
				end
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid   = ov_q;
	assign m_axis_tdata    = od_q;
	assign m_axis_tuser[0] = ou_q;
	assign m_axis_tlast    = ol_q;

endmodule

FILE: sv/cfrs_chk.sv
module cfrs_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tvalid,
	input logic                           s_axis_tready,
	input logic [cfrs_pkg::IN_DW-1:0]     s_axis_tdata,
	input logic                           s_axis_tlast,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [cfrs_pkg::OUT_DW-1:0]    m_axis_tdata,
	input logic [0:0]                     m_axis_tuser,
	input logic                           m_axis_tlast,
	input logic                           cfg_we,
	input logic [cfrs_pkg::CFG_IW-1:0]    cfg_idx,
	input logic [cfrs_pkg::CFG_DW-1:0]    cfg_wdata
);
	logic exp_bot_q;

	// vertices leave in top/bottom pairs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			exp_bot_q <= 1'b0;
		else if (m_axis_tvalid && m_axis_tready)
			exp_bot_q <= !exp_bot_q;
	end

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready |-> m_axis_tuser[0] == exp_bot_q)
		else $error("vertex side out of order");

	a_last_bottom: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[0])
		else $error("strip end on a top vertex");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("point taken while busy");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled vertex changed");

endmodule

bind camera_facing_ribbon_strip_unit cfrs_chk u_cfrs_chk (.*);

FILE: bench/tb_top.sv
// One output vertex as it appears on the master side.
typedef struct {
	logic [31:0] pos_x;
	logic [31:0] pos_y;
	logic [31:0] pos_z;
	logic [47:0] nrm;
	logic [47:0] bin;
	logic [47:0] tan;
	logic [31:0] tex_v;
	logic        bottom;
	logic        strip_end;
} vertex_t;

typedef longint  coord3_t [3];
typedef int      basis3_t [3];

// Strip predictor plus a FIFO of vertices still owed by the block.
class ribbon_scoreboard;
	longint          eye [3];
	longint          width;
	longint unsigned tex_len;
	longint          held_pt [3];
	int              held_nrm [3];
	int              held_bin [3];
	int              held_tan [3];
	longint unsigned tex_acc;
	bit              have_pt;
	bit              have_basis;
	vertex_t         owed [$];
	int              errors;

	function new();
		eye = '{0, 0, 0};
		width = 6554;
		tex_len = 13107;
		errors = 0;
		clear_strip();
	endfunction

	function void clear_strip();
		held_pt = '{0, 0, 0};
		held_nrm = '{0, 0, 0};
		held_bin = '{0, 0, 0};
		held_tan = '{0, 0, 0};
		tex_acc = 0;
		have_pt = 0;
		have_basis = 0;
	endfunction

	function void write_reg(int idx, logic [31:0] val);
		case (idx)
			cfrs_pkg::REG_EYE_X:   eye[0] = longint'($signed(val));
			cfrs_pkg::REG_EYE_Y:   eye[1] = longint'($signed(val));
			cfrs_pkg::REG_EYE_Z:   eye[2] = longint'($signed(val));
			cfrs_pkg::REG_CHAIN_W: width = longint'(val[30:0]);
			cfrs_pkg::REG_TEX_LEN: tex_len = longint'(val[30:0]);
			default: ;
		endcase
	endfunction

	function longint unsigned mag(longint v);
		return (v < 0) ? longint'(-v) : v;
	endfunction

	// smallest right shift bringing every magnitude below 2^31
	function int shrink_amt(coord3_t v);
		longint unsigned mx;
		int s;
		mx = 0;
		s = 0;
		for (int i = 0; i < 3; i++)
			if (mag(v[i]) > mx)
				mx = mag(v[i]);
		while ((mx >> s) >= (64'd1 << 31))
			s++;
		return s;
	endfunction

	function longint unsigned root(longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x)
			b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// unit vector in Q1.14; returns length in input units
	function longint unsigned unit_vec(coord3_t v, output basis3_t o);
		int s;
		longint unsigned m [3];
		longint unsigned sum, len, q;
		s = shrink_amt(v);
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] = mag(v[i]) >> s;
			sum += m[i] * m[i];
		end
		len = root(sum);
		o = '{0, 0, 0};
		if (len == 0)
			return 0;
		for (int i = 0; i < 3; i++) begin
			q = (m[i] << cfrs_pkg::VEC_FRAC_BITS) / len;
			if (q > 32767)
				q = 32767;
			o[i] = (v[i] < 0) ? -int'(q) : int'(q);
		end
		return len << s;
	endfunction

	function coord3_t cross_prod(coord3_t a, coord3_t b);
		coord3_t c;
		c[0] = a[1] * b[2] - a[2] * b[1];
		c[1] = a[2] * b[0] - a[0] * b[2];
		c[2] = a[0] * b[1] - a[1] * b[0];
		return c;
	endfunction

	function logic [47:0] pack(basis3_t v);
		return {16'(v[0]), 16'(v[1]), 16'(v[2])};
	endfunction

	function logic [31:0] sat32(longint v);
		if (v > 64'sh7FFF_FFFF)
			return 32'h7FFF_FFFF;
		if (v < -64'sh8000_0000)
			return 32'h8000_0000;
		return v[31:0];
	endfunction

	function void owe_pair(coord3_t p, basis3_t n, basis3_t b, basis3_t t, bit fin);
		vertex_t vx;
		longint off [3];
		for (int i = 0; i < 3; i++)
			off[i] = (longint'(b[i]) * width) / (64'sd1 << (cfrs_pkg::VEC_FRAC_BITS + 1));
		for (int side = 0; side < 2; side++) begin
			vx.pos_x = sat32(side ? p[0] - off[0] : p[0] + off[0]);
			vx.pos_y = sat32(side ? p[1] - off[1] : p[1] + off[1]);
			vx.pos_z = sat32(side ? p[2] - off[2] : p[2] + off[2]);
			vx.nrm = pack(n);
			vx.bin = pack(b);
			vx.tan = pack(t);
			vx.tex_v = tex_acc[31:0];
			vx.bottom = side[0];
			vx.strip_end = fin && side;
			owed.push_back(vx);
		end
	endfunction

	// accepted point: work out the vertices it causes
	function void note_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit fin);
		coord3_t p, d, r, t64, b64, c;
		basis3_t t, b, n, an, ab, at;
		longint unsigned seg, tl;
		int s;
		p = '{longint'($signed(x)), longint'($signed(y)), longint'($signed(z))};
		if (have_pt) begin
			for (int i = 0; i < 3; i++) begin
				d[i] = p[i] - held_pt[i];
				r[i] = held_pt[i] + p[i] - 2 * eye[i];
			end
			seg = unit_vec(d, t);
			s = shrink_amt(r);
			for (int i = 0; i < 3; i++) begin
				r[i] = (r[i] < 0) ? -longint'(mag(r[i]) >> s) : longint'(mag(r[i]) >> s);
				t64[i] = t[i];
			end
			c = cross_prod(t64, r);
			void'(unit_vec(c, b));
			for (int i = 0; i < 3; i++)
				b64[i] = b[i];
			c = cross_prod(t64, b64);
			void'(unit_vec(c, n));
			for (int i = 0; i < 3; i++) begin
				an[i] = have_basis ? (n[i] + held_nrm[i]) / 2 : n[i];
				ab[i] = have_basis ? (b[i] + held_bin[i]) / 2 : b[i];
				at[i] = have_basis ? (t[i] + held_tan[i]) / 2 : t[i];
			end
			owe_pair(held_pt, an, ab, at, 0);
			tl = (tex_len == 0) ? 1 : tex_len;
			tex_acc += (seg << cfrs_pkg::TEX_FRAC) / tl;
			if (tex_acc > 64'hFFFF_FFFF)
				tex_acc = 64'hFFFF_FFFF;
			held_nrm = n;
			held_bin = b;
			held_tan = t;
			have_basis = 1;
		end
		held_pt = p;
		have_pt = 1;
		if (fin) begin
			owe_pair(p, held_nrm, held_bin, held_tan, 1);
			clear_strip();
		end
	endfunction

	function void cmp(string nm, logic [63:0] exp_v, logic [63:0] got_v);
		if (exp_v !== got_v) begin
			$display("%0t mismatch %s: expected %h actual %h", $time, nm, exp_v, got_v);
			errors++;
		end
	endfunction

	function void check_vertex(vertex_t got);
		vertex_t e;
		if (owed.size() == 0) begin
			$display("%0t unexpected vertex: expected none actual pos %h %h %h",
				$time, got.pos_x, got.pos_y, got.pos_z);
			errors++;
			return;
		end
		e = owed.pop_front();
		cmp("pos_x", e.pos_x, got.pos_x);
		cmp("pos_y", e.pos_y, got.pos_y);
		cmp("pos_z", e.pos_z, got.pos_z);
		cmp("normal", e.nrm, got.nrm);
		cmp("binormal", e.bin, got.bin);
		cmp("tangent", e.tan, got.tan);
		cmp("tex_v", e.tex_v, got.tex_v);
		cmp("bottom_side", e.bottom, got.bottom);
		cmp("strip_last", e.strip_end, got.strip_end);
	endfunction
endclass

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_valid = 1'b0;
	logic s_ready;
	logic [cfrs_pkg::IN_DW-1:0] s_data = '0;
	logic s_last = 1'b0;
	logic m_valid;
	logic m_ready = 1'b0;
	logic [cfrs_pkg::OUT_DW-1:0] m_data;
	logic [0:0] m_user;
	logic m_last;
	logic cfg_we = 1'b0;
	logic [cfrs_pkg::CFG_IW-1:0] cfg_idx = '0;
	logic [cfrs_pkg::CFG_DW-1:0] cfg_wdata = '0;

	// when set, neither side idles
	bit calm = 1'b0;
	int n_sent;
	ribbon_scoreboard sb = new();

	camera_facing_ribbon_strip_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_valid),
		.s_axis_tready (s_ready),
		.s_axis_tdata  (s_data),
		.s_axis_tlast  (s_last),
		.m_axis_tvalid (m_valid),
		.m_axis_tready (m_ready),
		.m_axis_tdata  (m_data),
		.m_axis_tuser  (m_user),
		.m_axis_tlast  (m_last),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_wdata     (cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// hard stop, well beyond the slowest legal run
	initial begin
		#30_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	// receiver: check every vertex transfer, stall about 22% of cycles
	always @(posedge clk) begin
		vertex_t got;
		if (arst_n && m_valid && m_ready) begin
			got.pos_x = m_data[31:0];
			got.pos_y = m_data[63:32];
			got.pos_z = m_data[95:64];
			got.nrm = m_data[143:96];
			got.bin = m_data[191:144];
			got.tan = m_data[239:192];
			got.tex_v = m_data[271:240];
			got.bottom = m_user[0];
			got.strip_end = m_last;
			sb.check_vertex(got);
		end
		m_ready <= calm || ($urandom_range(99) >= 22);
	end

	// one point transfer, with random idle cycles ahead of it
	task send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit fin);
		while (!calm && $urandom_range(99) < 22) begin
			s_valid <= 1'b0;
			@(posedge clk);
		end
		s_valid <= 1'b1;
		s_data <= {z, y, x};
		s_last <= fin;
		@(posedge clk);
		while (!s_ready)
			@(posedge clk);
		sb.note_point(x, y, z, fin);
		n_sent++;
	endtask

	// drain: all vertices back, then let a pending first point settle
	task drain();
		s_valid <= 1'b0;
		while (sb.owed.size() != 0)
			@(posedge clk);
		repeat (500) @(posedge clk);
	endtask

	// only while drained; also pokes an unused index, which must be ignored
	task set_config(logic [31:0] ex, logic [31:0] ey, logic [31:0] ez,
			logic [31:0] cw, logic [31:0] tl);
		logic [31:0] vals [5];
		vals = '{ex, ey, ez, cw, tl};
		for (int i = 0; i < 5; i++) begin
			cfg_we <= 1'b1;
			cfg_idx <= cfrs_pkg::CFG_IW'(i);
			cfg_wdata <= vals[i];
			sb.write_reg(i, vals[i]);
			@(posedge clk);
		end
		cfg_idx <= cfrs_pkg::CFG_IW'($urandom_range(7, 5));
		cfg_wdata <= $urandom;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task random_strip();
		int len;
		logic [31:0] base [3];
		logic [31:0] pt [3];
		len = $urandom_range(8, 1);
		for (int k = 0; k < 3; k++)
			base[k] = ($urandom_range(3) == 0) ? $urandom : 32'($signed($urandom) >>> 3);
		for (int j = 0; j < len; j++) begin
			for (int k = 0; k < 3; k++) begin
				if ($urandom_range(9) < 8) begin
					// walk: small random step from the previous point
					base[k] = base[k] + 32'($signed($urandom) >>> $urandom_range(20, 10));
					pt[k] = base[k];
				end else begin
					pt[k] = $urandom;
				end
			end
			send_point(pt[0], pt[1], pt[2], j == len - 1);
		end
	endtask

	initial begin
		n_sent = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset configuration
		send_point(32'd1, 32'd2, 32'd3, 1);                    // lone point strip
		send_point(32'd0, 32'd0, 32'd0, 0);
		send_point(32'h0001_0000, 32'd0, 32'd0, 1);
		send_point(32'h0002_0000, 32'h0003_0000, 32'd5, 0);   // zero-length segment
		send_point(32'h0002_0000, 32'h0003_0000, 32'd5, 0);
		send_point(32'h0004_0000, 32'hFFFF_0000, 32'd5, 1);
		send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
		send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
		send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 1);
		send_point(32'h0001_0000, 32'd0, 32'd0, 0);           // segment aimed at the eye
		send_point(32'h0002_0000, 32'd0, 32'd0, 1);

		// extremes: widest ribbon, zero texture length, far eye
		drain();
		set_config(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0);
		send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
		send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
		send_point(32'h8000_0000, 32'd0, 32'h7FFF_FFFF, 0);
		send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 1);

		// other extreme: no width, longest texture
		drain();
		set_config(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'hFFFF_FFFF);
		send_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 0);
		send_point(32'hFFFF_0000, 32'h0002_0000, 32'h0000_8000, 0);
		send_point(32'hFFFF_0000, 32'h8000_0000, 32'h0000_8000, 1);

		// random phases, each under its own configuration
		for (int ph = 0; ph < 4; ph++) begin
			drain();
			if (ph == 0)
				set_config(32'd0, 32'd0, 32'd0, 32'd6554, 32'd13107);
			else
				set_config($urandom_range(1) ? $urandom : 32'($signed($urandom) >>> 8),
					$urandom, 32'($signed($urandom) >>> 12),
					$urandom_range(1) ? $urandom : $urandom_range(200000),
					$urandom_range(1) ? $urandom : $urandom_range(70000));
			calm = (ph == 2);
			n_sent = 0;
			while (n_sent < 125) begin
				random_strip();
				// in phase 1, near the middle: hold off until the block has caught up
				if (ph == 1 && n_sent > 60 && n_sent < 70) begin
					s_valid <= 1'b0;
					while (sb.owed.size() != 0)
						@(posedge clk);
					@(posedge clk);
				end
			end
			calm = 1'b0;
		end

		drain();
		if (sb.errors == 0 && sb.owed.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
